// ===== design/ple_pkg.sv =====
package ple_pkg;

   // Size of the list and the widths that follow from it.
   localparam int unsigned DEPTH = 16;
   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam int unsigned VAL_W = 32;

   // Command codes carried in the opcode field.
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_INSERT     = 3'd2;
   localparam logic [2:0] OP_DELETE     = 3'd3;
   localparam logic [2:0] OP_SWAP       = 3'd4;
   localparam logic [2:0] OP_READ       = 3'd5;
   localparam logic [2:0] OP_CLEAR      = 3'd6;

   // Result status codes.
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   // Actions broadcast to the row of cells.
   localparam logic [1:0] ACT_HOLD   = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_SWAP   = 2'd3;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic [1:0]              action;
      logic [CNT_W-1:0]        pos;
      logic [CNT_W-1:0]        count;
      logic [IDX_W-1:0]        sec;
      logic signed [VAL_W-1:0] value;
      logic signed [VAL_W-1:0] swap_a;
      logic signed [VAL_W-1:0] swap_b;
   } cell_ctrl_type;

endpackage

// ===== design/ple_cell.sv =====
module ple_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic                             clock,
   input  ple_pkg::cell_ctrl_type           ctrl,
   input  logic signed [ple_pkg::VAL_W-1:0] left_value,
   input  logic signed [ple_pkg::VAL_W-1:0] right_value,
   output logic signed [ple_pkg::VAL_W-1:0] elem_value
);

   localparam logic [ple_pkg::CNT_W-1:0] MY_POS = ple_pkg::CNT_W'(IDX);
   localparam logic [ple_pkg::IDX_W-1:0] MY_IDX = ple_pkg::IDX_W'(IDX);

   logic signed [ple_pkg::VAL_W-1:0] elem_ff;
   logic signed [ple_pkg::VAL_W-1:0] elem_in;

   // Each cell decides from its own place whether it loads, shifts or holds.
   always_comb begin
      elem_in = elem_ff;
      case (ctrl.action)
         ple_pkg::ACT_INSERT: begin
            if (MY_POS == ctrl.pos) begin
               elem_in = ctrl.value;
            end else if (MY_POS > ctrl.pos && MY_POS <= ctrl.count) begin
               elem_in = left_value;
            end
         end
         ple_pkg::ACT_DELETE: begin
            if (MY_POS >= ctrl.pos && (MY_POS + 1'b1) < ctrl.count) begin
               elem_in = right_value;
            end
         end
         ple_pkg::ACT_SWAP: begin
            if (MY_IDX == ctrl.sec) begin
               elem_in = ctrl.swap_a;
            end else if (MY_POS == ctrl.pos) begin
               elem_in = ctrl.swap_b;
            end
         end
         default: begin
            elem_in = elem_ff;
         end
      endcase
   end

   // Element storage; its contents matter only below the element count.
   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign elem_value = elem_ff;

endmodule

// ===== design/positional_list_engine.sv =====
// Ordered list of up to 16 signed 32-bit values, held in a row of cells that
// shift toward their neighbors in parallel. Each request beat is one command
// and gives exactly one response beat with status, the new element count and
// the value read. Push, insert, delete, read, clear and rejected commands answer
// straight from idle and a valid swap passes through a swap state, because the
// row has a single read bus that fetches one element per cycle. The response
// waits in an output register, and the next command can be taken in the same
// cycle that the response is taken.
module positional_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], value[34:3], position[39:35], second_position[43:40]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], count[6:2], read_value[38:7]
   output logic [39:0] rsp_tdata
);

   localparam int unsigned DEPTH = ple_pkg::DEPTH;
   localparam int unsigned IDX_W = ple_pkg::IDX_W;
   localparam int unsigned CNT_W = ple_pkg::CNT_W;
   localparam int unsigned VAL_W = ple_pkg::VAL_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SWAP = 1'b1;

   // Request fields.
   logic [2:0]              req_opcode;
   logic signed [VAL_W-1:0] req_value;
   logic [CNT_W-1:0]        req_position;
   logic [IDX_W-1:0]        req_second_position;

   assign req_opcode          = req_tdata[2:0];
   assign req_value           = req_tdata[34:3];
   assign req_position        = req_tdata[39:35];
   assign req_second_position = req_tdata[43:40];

   logic                    state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        swap_pos_ff, swap_pos_in;
   logic [IDX_W-1:0]        swap_sec_ff, swap_sec_in;
   logic signed [VAL_W-1:0] swap_tmp_ff, swap_tmp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [VAL_W-1:0] rsp_read_ff, rsp_read_in;

   logic                    rsp_free;
   logic                    fire;
   logic                    full;
   logic                    rsp_load;
   logic [IDX_W-1:0]        rd_idx;
   logic signed [VAL_W-1:0] rd_bus;
   logic signed [VAL_W-1:0] cell_value [DEPTH];
   ple_pkg::cell_ctrl_type  ctrl;

   // Handshake: a new command needs the sequencer idle and the output free.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign fire       = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(DEPTH));

   // Single read bus over the row: first swap operand or read position on
   // acceptance, second swap operand in the swap cycle.
   assign rd_idx = (state_ff == ST_SWAP) ? swap_sec_ff : req_position[IDX_W-1:0];
   assign rd_bus = cell_value[rd_idx];

   // Command decode and sequencing.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      swap_pos_in   = swap_pos_ff;
      swap_sec_in   = swap_sec_ff;
      swap_tmp_in   = swap_tmp_ff;
      rsp_load      = 1'b0;
      rsp_status_in = ple_pkg::ST_DONE;
      rsp_read_in   = '0;
      ctrl.action   = ple_pkg::ACT_HOLD;
      ctrl.pos      = req_position;
      ctrl.count    = count_ff;
      ctrl.sec      = swap_sec_ff;
      ctrl.value    = req_value;
      ctrl.swap_a   = swap_tmp_ff;
      ctrl.swap_b   = rd_bus;

      if (state_ff == ST_SWAP) begin
         ctrl.action = ple_pkg::ACT_SWAP;
         ctrl.pos    = swap_pos_ff;
         rsp_load    = 1'b1;
         state_in    = ST_IDLE;
      end else if (fire) begin
         rsp_load = 1'b1;
         unique case (req_opcode) inside
            ple_pkg::OP_PUSH_FRONT, ple_pkg::OP_PUSH_BACK, ple_pkg::OP_INSERT: begin
               if (req_opcode == ple_pkg::OP_PUSH_FRONT) begin
                  ctrl.pos = '0;
               end else if (req_opcode == ple_pkg::OP_PUSH_BACK) begin
                  ctrl.pos = count_ff;
               end
               if (req_opcode == ple_pkg::OP_INSERT && req_position > count_ff) begin
                  rsp_status_in = ple_pkg::ST_BADPOS;
               end else if (full) begin
                  rsp_status_in = ple_pkg::ST_FULL;
               end else begin
                  ctrl.action = ple_pkg::ACT_INSERT;
                  count_in    = count_ff + 1'b1;
               end
            end
            ple_pkg::OP_DELETE: begin
               if (req_position >= count_ff) begin
                  rsp_status_in = ple_pkg::ST_BADPOS;
               end else begin
                  ctrl.action = ple_pkg::ACT_DELETE;
                  count_in    = count_ff - 1'b1;
               end
            end
            ple_pkg::OP_SWAP: begin
               if (req_position >= count_ff ||
                   CNT_W'(req_second_position) >= count_ff) begin
                  rsp_status_in = ple_pkg::ST_BADPOS;
               end else begin
                  // Fetch the first operand now, finish in the next cycle.
                  rsp_load    = 1'b0;
                  swap_pos_in = req_position;
                  swap_sec_in = req_second_position;
                  swap_tmp_in = rd_bus;
                  state_in    = ST_SWAP;
               end
            end
            ple_pkg::OP_READ: begin
               if (req_position >= count_ff) begin
                  rsp_status_in = ple_pkg::ST_BADPOS;
               end else begin
                  rsp_read_in = rd_bus;
               end
            end
            ple_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               rsp_status_in = ple_pkg::ST_BADPOS;
            end
         endcase
      end

      rsp_count_in = count_in;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   // Row of cells, each handing its value to both neighbors.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_v;
      logic signed [VAL_W-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = req_value;
      end else begin : g_left
         assign left_v = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_v = cell_value[i];
      end else begin : g_right
         assign right_v = cell_value[i+1];
      end
      ple_cell #(
         .IDX(i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_value (left_v),
         .right_value(right_v),
         .elem_value (cell_value[i])
      );
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Swap operands and the response payload.
   always_ff @(posedge clock) begin
      swap_pos_ff <= swap_pos_in;
      swap_sec_ff <= swap_sec_in;
      swap_tmp_ff <= swap_tmp_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_read_ff   <= rsp_read_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_read_ff, rsp_count_ff, rsp_status_ff};

`ifndef SYNTHESIS
   // The element count never passes the list size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above list size");

   // A swap leaves the swap state for idle and always answers.
   a_swap_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWAP |=> state_ff == ST_IDLE && rsp_tvalid)
      else $error("swap did not complete with a response");

   // No new command is taken while a swap is in flight.
   a_swap_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWAP |-> !req_tready)
      else $error("request taken during swap");

   // A swap never changes the element count.
   a_swap_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWAP |=> count_ff == $past(count_ff))
      else $error("swap changed the element count");
`endif

endmodule

// ===== verif/tb_positional_list_engine.sv =====
module tb_positional_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   // The encoding left over by the seven commands; the block rejects it.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // Fields of one request beat, opcode in the lowest bits.
   typedef struct packed {
      logic [ple_pkg::IDX_W-1:0]        second_position;
      logic [ple_pkg::CNT_W-1:0]        position;
      logic signed [ple_pkg::VAL_W-1:0] value;
      logic [2:0]                       opcode;
   } list_cmd_type;

   // Fields of one response beat, status in the lowest bits.
   typedef struct packed {
      logic signed [ple_pkg::VAL_W-1:0] read_value;
      logic [ple_pkg::CNT_W-1:0]        count;
      logic [1:0]                       status;
   } list_answer_type;

   // Contents of the list as the block should hold them.
   typedef struct {
      logic signed [ple_pkg::VAL_W-1:0] elems [ple_pkg::DEPTH];
      logic [ple_pkg::CNT_W-1:0]        count;
   } list_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   list_cmd_type    pending_commands [$];
   list_answer_type expected_answers [$];
   list_state_type  shadow_list;
   list_state_type  planned_list;
   int              commands_accepted = 0;
   int              total_commands = 0;
   int              failures = 0;
   int              req_gap = 0;
   int              rsp_stall = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;

   positional_list_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one command to a list and returns the response it should give.
   function automatic list_answer_type apply_command(inout list_state_type lst,
                                                     input list_cmd_type cmd);
      list_answer_type                  ans;
      logic [ple_pkg::CNT_W-1:0]        slot;
      logic signed [ple_pkg::VAL_W-1:0] held;
      ans.status     = ple_pkg::ST_DONE;
      ans.read_value = '0;
      case (cmd.opcode) inside
         ple_pkg::OP_PUSH_FRONT, ple_pkg::OP_PUSH_BACK, ple_pkg::OP_INSERT: begin
            if (cmd.opcode == ple_pkg::OP_PUSH_FRONT) slot = '0;
            else if (cmd.opcode == ple_pkg::OP_PUSH_BACK) slot = lst.count;
            else slot = cmd.position;
            // A bad insert position is reported ahead of a full list.
            if (cmd.opcode == ple_pkg::OP_INSERT && cmd.position > lst.count) begin
               ans.status = ple_pkg::ST_BADPOS;
            end else if (lst.count == ple_pkg::DEPTH) begin
               ans.status = ple_pkg::ST_FULL;
            end else begin
               for (int i = ple_pkg::DEPTH - 1; i > 0; i--)
                  if (i <= lst.count && i > slot) lst.elems[i] = lst.elems[i-1];
               lst.elems[slot] = cmd.value;
               lst.count++;
            end
         end
         ple_pkg::OP_DELETE: begin
            if (cmd.position >= lst.count) begin
               ans.status = ple_pkg::ST_BADPOS;
            end else begin
               for (int i = 0; i < ple_pkg::DEPTH - 1; i++)
                  if (i >= cmd.position) lst.elems[i] = lst.elems[i+1];
               lst.count--;
            end
         end
         ple_pkg::OP_SWAP: begin
            if (cmd.position >= lst.count || cmd.second_position >= lst.count) begin
               ans.status = ple_pkg::ST_BADPOS;
            end else begin
               held = lst.elems[cmd.position];
               lst.elems[cmd.position] = lst.elems[cmd.second_position];
               lst.elems[cmd.second_position] = held;
            end
         end
         ple_pkg::OP_READ: begin
            if (cmd.position >= lst.count) ans.status = ple_pkg::ST_BADPOS;
            else ans.read_value = lst.elems[cmd.position];
         end
         ple_pkg::OP_CLEAR: lst.count = '0;
         default: ans.status = ple_pkg::ST_BADPOS;
      endcase
      ans.count = lst.count;
      return ans;
   endfunction

   // Mostly random values, with the extremes mixed in.
   function automatic logic [ple_pkg::VAL_W-1:0] pick_value();
      if ($urandom_range(0, 9) != 0) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Queues one command and tracks the list length it leaves behind.
   task automatic add_command(input logic [2:0] op,
                              input logic [ple_pkg::VAL_W-1:0] val,
                              input int pos, input int sec);
      list_cmd_type cmd;
      cmd.opcode          = op;
      cmd.value           = val;
      cmd.position        = ple_pkg::CNT_W'(pos);
      cmd.second_position = ple_pkg::IDX_W'(sec);
      void'(apply_command(planned_list, cmd));
      pending_commands.push_back(cmd);
   endtask

   // Idling is off in the tail of the run and in every fourth stretch.
   function automatic bit idle_now(int percent);
      if (commands_accepted >= total_commands - 150) return 1'b0;
      if ((commands_accepted / 64) % 4 == 0) return 1'b0;
      return $urandom_range(0, 99) < percent;
   endfunction

   // Stimulus, then the wait for the last response and the verdict.
   initial begin
      int         n;
      int         r;
      int         pos;
      int         sec;
      bit         growing;
      logic [2:0] op;
      planned_list.count = '0;
      shadow_list.count  = '0;

      // Empty list: every positional command is out of range.
      add_command(ple_pkg::OP_READ, 32'h1234_5678, 0, 0);
      add_command(ple_pkg::OP_DELETE, 0, 0, 0);
      add_command(ple_pkg::OP_SWAP, 0, 0, 0);
      add_command(ple_pkg::OP_INSERT, 32'h5555_5555, 1, 0);
      // Build a short list from both ends and the middle.
      add_command(ple_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 0, 0);
      add_command(ple_pkg::OP_PUSH_FRONT, 32'h8000_0000, 0, 0);
      add_command(ple_pkg::OP_INSERT, 32'h0000_0000, 2, 0);
      add_command(ple_pkg::OP_INSERT, 32'hFFFF_FFFF, 1, 0);
      add_command(ple_pkg::OP_READ, 0, 3, 0);
      add_command(ple_pkg::OP_SWAP, 0, 0, 3);
      add_command(ple_pkg::OP_SWAP, 0, 2, 2);
      add_command(ple_pkg::OP_SWAP, 0, 1, 4);
      add_command(ple_pkg::OP_DELETE, 0, 4, 0);
      add_command(ple_pkg::OP_DELETE, 0, 0, 0);
      add_command(OP_UNUSED, 32'hFFFF_FFFF, 31, 15);
      add_command(ple_pkg::OP_READ, 0, 31, 0);
      // Fill up and knock on the full list.
      while (planned_list.count < ple_pkg::DEPTH)
         add_command(ple_pkg::OP_PUSH_BACK, pick_value(), 0, 0);
      add_command(ple_pkg::OP_PUSH_FRONT, 32'h2222_2222, 0, 0);
      add_command(ple_pkg::OP_INSERT, 32'h3333_3333, 16, 0);
      add_command(ple_pkg::OP_INSERT, 32'h4444_4444, 17, 0);
      add_command(ple_pkg::OP_READ, 0, 15, 0);
      add_command(ple_pkg::OP_CLEAR, 0, 0, 0);

      // Random part: the list drifts between empty and full.
      growing = 1'b1;
      for (int k = 0; k < 1250; k++) begin
         n = planned_list.count;
         if (n == 0) growing = 1'b1;
         else if (n == ple_pkg::DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
         else if ($urandom_range(0, 99) == 0) growing = !growing;
         r = $urandom_range(0, 99);
         if (r < 1) op = ple_pkg::OP_CLEAR;
         else if (r < 3) op = OP_UNUSED;
         else if (r < 22) op = ple_pkg::OP_READ;
         else if (r < 34) op = ple_pkg::OP_SWAP;
         else if (growing)
            op = (r < 44) ? ple_pkg::OP_DELETE : (r < 62) ? ple_pkg::OP_PUSH_FRONT :
                 (r < 80) ? ple_pkg::OP_PUSH_BACK : ple_pkg::OP_INSERT;
         else
            op = (r < 80) ? ple_pkg::OP_DELETE : (r < 86) ? ple_pkg::OP_PUSH_FRONT :
                 (r < 92) ? ple_pkg::OP_PUSH_BACK : ple_pkg::OP_INSERT;
         if ($urandom_range(0, 19) == 0) begin
            pos = $urandom_range(0, 31);
            sec = $urandom_range(0, 15);
         end else begin
            if (op == ple_pkg::OP_INSERT) pos = $urandom_range(0, n);
            else pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
            sec = (n > 0) ? $urandom_range(0, n - 1) : 0;
         end
         add_command(op, pick_value(), pos, sec);
      end
      total_commands = pending_commands.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (commands_accepted < total_commands || expected_answers.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // Driver: predicts each accepted beat and offers the next command.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_answers.push_back(apply_command(shadow_list,
                                                     list_cmd_type'(req_tdata[43:0])));
            commands_accepted <= commands_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_commands.size() != 0) begin
               req_tdata  <= {4'b0, pending_commands.pop_front()};
               req_tvalid <= 1'b1;
               if (idle_now(20)) req_gap <= $urandom_range(1, 8);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus one long hold that backs the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (!hold_done && commands_accepted >= 400) begin
         hold_done  <= 1'b1;
         hold_left  <= 120;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (idle_now(15)) begin
         rsp_stall  <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: each response beat against the oldest prediction.
   always @(posedge clock) begin
      list_answer_type got;
      list_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = list_answer_type'(rsp_tdata[38:0]);
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time,
                     rsp_tdata);
            failures++;
         end else begin
            want = expected_answers.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                        want.status, got.status);
               failures++;
            end
            if (got.count !== want.count) begin
               $display("%0t: count mismatch, expected %0d, actual %0d", $time,
                        want.count, got.count);
               failures++;
            end
            if (got.read_value !== want.read_value) begin
               $display("%0t: read value mismatch, expected %0d, actual %0d", $time,
                        want.read_value, got.read_value);
               failures++;
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine.sv
verif/tb_positional_list_engine.sv
